@@ rtl/rmq_pkg.sv @@
// ============================================================================
// rmq_pkg - shared types and constants
// Sizes, tree node layout and the item/config/result records passed between
// the range query top level and its tree walker.
// ============================================================================
`default_nettype none

package rmq_pkg;

   // Positions in the tree (power of two); heap node n has children 2n, 2n+1,
   // root is node 1, leaf for position p is node LEAVES + p.
   localparam int LEAVES     = 1024;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(LEAVES);
   localparam int ADDR_BITS  = IDX_BITS + 1;   // node address
   localparam int PTR_BITS   = IDX_BITS + 2;   // query bound, can reach 2*LEAVES
   localparam int SIZE_BITS  = IDX_BITS + 1;   // active size, 0..LEAVES and beyond
   localparam int NODES      = 2 * LEAVES;

   // Request kinds
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Register indexes
   localparam logic CSR_FIND_MIN    = 1'b0;
   localparam logic CSR_ACTIVE_SIZE = 1'b1;

   // One tree node: best written position below it and its value
   typedef struct packed {
      logic                  valid;
      logic [IDX_BITS-1:0]   idx;
      logic [VALUE_BITS-1:0] value;
   } node_type;

   localparam int NODE_BITS = $bits(node_type);

   typedef struct packed {
      logic                  req_type;
      logic [IDX_BITS-1:0]   update_index;
      logic [VALUE_BITS-1:0] new_value;
      logic [IDX_BITS-1:0]   range_start;
      logic [IDX_BITS-1:0]   range_end;
   } req_item_type;

   typedef struct packed {
      logic                 find_min;
      logic [SIZE_BITS-1:0] size;      // active size clamped to LEAVES
   } cfg_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] best_index;
      logic                found;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/rmq_if.sv @@
// ============================================================================
// rmq_if - request and response channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ============================================================================
`default_nettype none

interface rmq_req_if;
   import rmq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [IDX_BITS-1:0]   update_index;
   logic signed [VALUE_BITS-1:0] new_value;
   logic [IDX_BITS-1:0]   range_start;
   logic [IDX_BITS-1:0]   range_end;

   modport source (output valid, output req_type, output update_index,
                   output new_value, output range_start, output range_end,
                   input ready);
   modport sink (input valid, input req_type, input update_index,
                 input new_value, input range_start, input range_end,
                 output ready);
endinterface

interface rmq_rsp_if;
   import rmq_pkg::*;

   logic                valid;
   logic                ready;
   logic [IDX_BITS-1:0] best_index;
   logic                found;

   modport source (output valid, output best_index, output found, input ready);
   modport sink (input valid, input best_index, input found, output ready);
endinterface

`default_nettype wire

@@ rtl/indexed_range_min_max_query.sv @@
// ============================================================================
// indexed_range_min_max_query - indexed segment tree, range min/max position
// Updates store a value at a position and refresh the best-index path to the
// root; queries return the position of the min or max over a clipped range.
// ============================================================================
//
//  Channel   Dir  Handshake            Payload
//  req_bus   in   valid/ready          req_type, update_index, new_value,
//                                      range_start, range_end
//  rsp_bus   out  valid/ready          best_index, found
//  csr_*     in   write enable only    csr_index, csr_write_data (11 bits)
//
//  Update: leaf write, then one read-modify-write per tree level.
//  Query: one tree level per cycle on the two RAM read ports.
//  Dropped updates (position at or beyond active size) write nothing to the tree.
//  After reset a clearing pass over every node empties the node RAM; req_bus
//  is not ready until it ends.
//  A finished result sits in the output register; a new item is taken while
//  it waits, and the next query stalls in its last cycle until it is taken.
//
`default_nettype none

module indexed_range_min_max_query
   import rmq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   rmq_req_if.sink                   req_bus,
   rmq_rsp_if.source                 rsp_bus,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_index,
   input  wire logic [SIZE_BITS-1:0] csr_write_data
);

   logic                 find_min_ff, find_min_in;
   logic [SIZE_BITS-1:0] active_size_ff, active_size_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_data_ff, rsp_data_in;

   cfg_type      cfg;
   req_item_type item;
   result_type   result;
   logic         walker_idle;
   logic         out_push;
   logic         out_free;
   logic         start;

   // Registers
   always_comb begin
      find_min_in    = find_min_ff;
      active_size_in = active_size_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIND_MIN:    find_min_in    = csr_write_data[0];
            CSR_ACTIVE_SIZE: active_size_in = csr_write_data;
            default:         ;
         endcase
      end
   end

   assign cfg.find_min = find_min_ff;
   assign cfg.size     = (active_size_ff > SIZE_BITS'(LEAVES)) ? SIZE_BITS'(LEAVES)
                                                               : active_size_ff;

   // Input transfer
   assign req_bus.ready     = walker_idle;
   assign start             = req_bus.valid && walker_idle;
   assign item.req_type     = req_bus.req_type;
   assign item.update_index = req_bus.update_index;
   assign item.new_value    = req_bus.new_value;
   assign item.range_start  = req_bus.range_start;
   assign item.range_end    = req_bus.range_end;

   rmq_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (item),
      .cfg      (cfg),
      .out_free (out_free),
      .idle     (walker_idle),
      .out_push (out_push),
      .result   (result)
   );

   // Output register
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = out_push || (rsp_valid_ff && !rsp_bus.ready);
   assign rsp_data_in  = out_push ? result : rsp_data_ff;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.best_index = rsp_data_ff.best_index;
   assign rsp_bus.found      = rsp_data_ff.found;

   always_ff @(posedge clock) begin
      if (reset) begin
         find_min_ff    <= 1'b1;
         active_size_ff <= SIZE_BITS'(LEAVES);
         rsp_valid_ff   <= 1'b0;
      end else begin
         find_min_ff    <= find_min_in;
         active_size_ff <= active_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ rtl/rmq_ram.sv @@
// ============================================================================
// rmq_ram - generic synchronous RAM
// One write port, two read ports, read data registered.
// ============================================================================
`default_nettype none

module rmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr0,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr1,
   output logic      [WIDTH-1:0]         read_data0,
   output logic      [WIDTH-1:0]         read_data1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data0 <= mem[read_addr0];
      read_data1 <= mem[read_addr1];
   end

endmodule

`default_nettype wire

@@ rtl/rmq_walker.sv @@
// ============================================================================
// rmq_walker - tree sequencer
// Clears the node RAM after reset, walks leaf-to-root on updates and runs the
// bottom-up range search on queries, one tree level per cycle.
// ============================================================================
`default_nettype none

module rmq_walker
   import rmq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   input  wire logic         out_free,
   output logic              idle,
   output logic              out_push,
   output result_type        result
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_UPD   = 3'd2;
   localparam logic [2:0] ST_QRY   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   localparam logic [ADDR_BITS-1:0] ROOT      = ADDR_BITS'(1);
   localparam logic [PTR_BITS-1:0]  LEAF_BASE = PTR_BITS'(LEAVES);

   // Better of two candidates; the order is total, so merge order is free.
   // Minimum: ties go to the higher position. Maximum: to the lower one.
   function automatic node_type pick(input node_type a, input node_type b,
                                     input logic find_min);
      logic a_lt;
      logic a_eq;
      logic a_wins;
      begin
         a_lt = $signed(a.value) < $signed(b.value);
         a_eq = a.value == b.value;
         if (find_min) begin
            a_wins = a_lt || (a_eq && (a.idx > b.idx));
         end else begin
            a_wins = (!a_lt && !a_eq) || (a_eq && (a.idx < b.idx));
         end
         if (!a.valid) begin
            pick = b;
         end else if (!b.valid) begin
            pick = a;
         end else begin
            pick = a_wins ? a : b;
         end
      end
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [ADDR_BITS-1:0] cur_ff, cur_in;
   node_type             cur_node_ff, cur_node_in;
   logic [PTR_BITS-1:0]  l_ff, l_in;
   logic [PTR_BITS-1:0]  r_ff, r_in;
   logic                 take_l_ff, take_l_in;
   logic                 take_r_ff, take_r_in;
   node_type             acc_l_ff, acc_l_in;
   node_type             acc_r_ff, acc_r_in;

   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_waddr;
   logic [NODE_BITS-1:0] ram_wdata;
   logic [ADDR_BITS-1:0] ram_raddr0;
   logic [ADDR_BITS-1:0] ram_raddr1;
   logic [NODE_BITS-1:0] ram_rdata0;
   logic [NODE_BITS-1:0] ram_rdata1;

   node_type             rd0_node;
   node_type             rd1_node;
   node_type             leaf_node;
   node_type             left_node;
   node_type             right_node;
   node_type             parent_node;
   node_type             best_node;
   logic [ADDR_BITS-1:0] leaf_addr;
   logic [ADDR_BITS-1:0] parent_addr;
   logic                 upd_drop;
   logic [SIZE_BITS-1:0] size_m1;
   logic [SIZE_BITS-1:0] qe_clip;
   logic                 q_empty;
   logic [PTR_BITS-1:0]  q_l;
   logic [PTR_BITS-1:0]  q_r;
   logic [PTR_BITS-1:0]  l_step;
   logic [PTR_BITS-1:0]  r_m1;
   logic [PTR_BITS-1:0]  r_step;

   rmq_ram #(
      .WIDTH (NODE_BITS),
      .DEPTH (NODES)
   ) u_tree (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_addr0   (ram_raddr0),
      .read_addr1   (ram_raddr1),
      .read_data0   (ram_rdata0),
      .read_data1   (ram_rdata1)
   );

   assign rd0_node = node_type'(ram_rdata0);
   assign rd1_node = node_type'(ram_rdata1);

   // Update decode
   assign leaf_addr = {1'b1, item.update_index};
   assign upd_drop  = {1'b0, item.update_index} >= cfg.size;
   always_comb begin
      leaf_node       = '0;
      leaf_node.valid = 1'b1;
      leaf_node.idx   = item.update_index;
      leaf_node.value = item.new_value;
   end

   // Query decode: half-open leaf bounds, end clipped to the active size
   assign size_m1 = cfg.size - SIZE_BITS'(1);
   assign qe_clip = ({1'b0, item.range_end} > size_m1) ? size_m1 : {1'b0, item.range_end};
   assign q_empty = (cfg.size == '0) || ({1'b0, item.range_start} > qe_clip);
   assign q_l     = PTR_BITS'(item.range_start) + LEAF_BASE;
   assign q_r     = q_empty ? q_l : (PTR_BITS'(qe_clip) + LEAF_BASE + PTR_BITS'(1));

   // Walk-up combine: the node just written plus its sibling from RAM
   assign parent_addr = cur_ff >> 1;
   assign left_node   = cur_ff[0] ? rd0_node : cur_node_ff;
   assign right_node  = cur_ff[0] ? cur_node_ff : rd0_node;
   assign parent_node = pick(left_node, right_node, cfg.find_min);

   // Query bound steps
   assign l_step = l_ff + PTR_BITS'(l_ff[0]);
   assign r_m1   = r_ff - PTR_BITS'(1);
   assign r_step = r_ff[0] ? r_m1 : r_ff;

   // Final answer from both accumulators
   assign best_node         = pick(acc_l_ff, acc_r_ff, cfg.find_min);
   assign result.found      = best_node.valid;
   assign result.best_index = best_node.valid ? best_node.idx : '0;

   assign idle = state_ff == ST_IDLE;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cur_in      = cur_ff;
      cur_node_in = cur_node_ff;
      l_in        = l_ff;
      r_in        = r_ff;
      take_l_in   = 1'b0;
      take_r_in   = 1'b0;
      acc_l_in    = acc_l_ff;
      acc_r_in    = acc_r_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = '0;
      ram_raddr0  = '0;
      ram_raddr1  = '0;
      out_push    = 1'b0;

      // merge nodes read in the previous cycle
      if (take_l_ff) begin
         acc_l_in = pick(acc_l_ff, rd0_node, cfg.find_min);
      end
      if (take_r_ff) begin
         acc_r_in = pick(rd1_node, acc_r_ff, cfg.find_min);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_BITS'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (item.req_type == REQ_UPDATE) begin
                  if (!upd_drop) begin
                     ram_we      = 1'b1;
                     ram_waddr   = leaf_addr;
                     ram_wdata   = leaf_node;
                     ram_raddr0  = leaf_addr ^ ADDR_BITS'(1);
                     cur_in      = leaf_addr;
                     cur_node_in = leaf_node;
                     state_in    = ST_UPD;
                  end
               end else begin
                  l_in     = q_l;
                  r_in     = q_r;
                  acc_l_in = '0;
                  acc_r_in = '0;
                  state_in = ST_QRY;
               end
            end
         end
         ST_UPD: begin
            ram_we      = 1'b1;
            ram_waddr   = parent_addr;
            ram_wdata   = parent_node;
            ram_raddr0  = parent_addr ^ ADDR_BITS'(1);
            cur_in      = parent_addr;
            cur_node_in = parent_node;
            if (parent_addr == ROOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY: begin
            if (l_ff < r_ff) begin
               take_l_in  = l_ff[0];
               take_r_in  = r_ff[0];
               ram_raddr0 = l_ff[ADDR_BITS-1:0];
               ram_raddr1 = r_m1[ADDR_BITS-1:0];
               l_in       = l_step >> 1;
               r_in       = r_step >> 1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               out_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         take_l_ff <= 1'b0;
         take_r_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         take_l_ff <= take_l_in;
         take_r_ff <= take_r_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      cur_node_ff <= cur_node_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      acc_l_ff    <= acc_l_in;
      acc_r_ff    <= acc_r_in;
   end

   // Search bounds never cross
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QRY |-> l_ff <= r_ff)
      else $error("query bounds crossed");

   // Update walk climbs exactly one level per cycle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD |=>
         (state_ff == ST_UPD && cur_ff == ($past(cur_ff) >> 1)) || state_ff == ST_IDLE)
      else $error("update walk skipped a level");

   // Queries never write the tree
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY || state_ff == ST_FIN) |-> !ram_we)
      else $error("tree written during a query");

   // A result is never pushed in two consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      out_push |=> !out_push)
      else $error("back-to-back result pushes");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb - indexed range min/max query testbench
// Drives updates and range queries over the request channel, writes the mode
// and size registers between phases and checks every query result against a
// mirror segment tree kept in the testbench. A short table of directed items
// covers the corners first, then random phases run over several settings.
// ============================================================================

module tb;
   import rmq_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 16;   // longest update walk plus margin
   localparam int DRAIN_CYCLES  = 20;
   localparam int PHASES        = 9;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One directed table row: an item (optionally with a known result) or a
   // register write
   typedef struct packed {
      row_kind_type         kind;
      req_item_type         item;
      logic                 known;
      result_type           known_result;
      logic                 csr_sel;
      logic [SIZE_BITS-1:0] csr_data;
   } stim_row_type;

   // Best written position below a tree node
   typedef struct packed {
      logic                ok;
      logic [IDX_BITS-1:0] pos;
   } pick_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic                 csr_index;
   logic [SIZE_BITS-1:0] csr_write_data;

   rmq_req_if req_ch ();
   rmq_rsp_if rsp_ch ();

   indexed_range_min_max_query u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_ch),
      .rsp_bus          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Mirror of the block state
   logic                         mode_min;
   logic [SIZE_BITS-1:0]         size_reg;
   logic signed [VALUE_BITS-1:0] value_mirror [LEAVES];
   pick_type                     best_tree [2*LEAVES];

   result_type   pending_results [$];
   result_type   oldest_result;
   stim_row_type directed_rows [$];

   bit idle_on = 1'b1;
   int stall_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int updates_sent = 0;
   int queries_sent = 0;
   int results_checked = 0;

   int phase_size  [PHASES] = '{1024, 1024, 2047, 13, 1, 0, 300, 64, 1024};
   bit phase_min   [PHASES] = '{1, 0, 0, 1, 1, 0, 0, 1, 1};
   int phase_items [PHASES] = '{260, 240, 200, 200, 60, 40, 220, 200, 200};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_size(logic [SIZE_BITS-1:0] s);
      return (s > LEAVES) ? LEAVES : int'(s);
   endfunction

   // Left/right merge: ties go to the right for min, to the left for max
   function automatic pick_type better_of(pick_type left_pick, pick_type right_pick);
      if (!left_pick.ok) return right_pick;
      if (!right_pick.ok) return left_pick;
      if (mode_min)
         return (value_mirror[left_pick.pos] < value_mirror[right_pick.pos]) ?
                left_pick : right_pick;
      return (value_mirror[left_pick.pos] < value_mirror[right_pick.pos]) ?
             right_pick : left_pick;
   endfunction

   // Store a value and refresh the path from its leaf to the root
   function automatic void apply_update(logic [IDX_BITS-1:0] pos,
                                        logic signed [VALUE_BITS-1:0] val);
      int node;
      if (pos >= clamp_size(size_reg)) return;
      value_mirror[pos] = val;
      node = LEAVES + int'(pos);
      best_tree[node] = '{ok: 1'b1, pos: pos};
      node = node / 2;
      while (node >= 1) begin
         best_tree[node] = better_of(best_tree[2*node], best_tree[2*node+1]);
         node = node / 2;
      end
   endfunction

   // Bottom-up walk over the clipped range, keeping left-to-right order
   function automatic result_type predict_query(logic [IDX_BITS-1:0] first,
                                                logic [IDX_BITS-1:0] last);
      int         span;
      int         lo;
      int         hi;
      pick_type   left_acc;
      pick_type   right_acc;
      pick_type   best;
      result_type res;
      res       = '0;
      left_acc  = '0;
      right_acc = '0;
      span      = clamp_size(size_reg);
      if (span == 0) return res;
      hi = (int'(last) > span - 1) ? span - 1 : int'(last);
      if (int'(first) > hi) return res;
      lo = int'(first) + LEAVES;
      hi = hi + LEAVES + 1;
      while (lo < hi) begin
         if (lo % 2 == 1) begin
            left_acc = better_of(left_acc, best_tree[lo]);
            lo++;
         end
         if (hi % 2 == 1) begin
            hi--;
            right_acc = better_of(best_tree[hi], right_acc);
         end
         lo = lo / 2;
         hi = hi / 2;
      end
      best           = better_of(left_acc, right_acc);
      res.found      = best.ok;
      res.best_index = best.ok ? best.pos : '0;
      return res;
   endfunction

   // Directed table row builders
   function automatic stim_row_type stim_update(int pos, logic [VALUE_BITS-1:0] val);
      stim_row_type row;
      row                   = '0;
      row.kind              = ROW_ITEM;
      row.item.req_type     = REQ_UPDATE;
      row.item.update_index = IDX_BITS'(pos);
      row.item.new_value    = val;
      return row;
   endfunction

   function automatic stim_row_type stim_query(int first, int last, logic known,
                                               int idx, logic found);
      stim_row_type row;
      row                         = '0;
      row.kind                    = ROW_ITEM;
      row.item.req_type           = REQ_QUERY;
      row.item.range_start        = IDX_BITS'(first);
      row.item.range_end          = IDX_BITS'(last);
      row.known                   = known;
      row.known_result.best_index = IDX_BITS'(idx);
      row.known_result.found      = found;
      return row;
   endfunction

   function automatic stim_row_type stim_csr(logic sel, int data);
      stim_row_type row;
      row          = '0;
      row.kind     = ROW_CSR;
      row.csr_sel  = sel;
      row.csr_data = SIZE_BITS'(data);
      return row;
   endfunction

   // Random item: mostly in-range updates and queries, small values for ties
   function automatic req_item_type random_request(int span);
      req_item_type it;
      int           first;
      int           last;
      int           swap;
      it.req_type     = ($urandom_range(0, 99) < 55) ? REQ_UPDATE : REQ_QUERY;
      it.update_index = IDX_BITS'($urandom);
      it.new_value    = $urandom;
      it.range_start  = IDX_BITS'($urandom);
      it.range_end    = IDX_BITS'($urandom);
      if (it.req_type == REQ_UPDATE) begin
         if (span > 0 && $urandom_range(0, 9) != 0)
            it.update_index = IDX_BITS'($urandom_range(0, span - 1));
         case ($urandom_range(0, 5))
            0: it.new_value = 32'h8000_0000;
            1: it.new_value = 32'h7FFF_FFFF;
            2, 3: it.new_value = $urandom_range(0, 6) - 3;
            default: ;
         endcase
      end else if (span > 0 && $urandom_range(0, 9) != 0) begin
         first = $urandom_range(0, span - 1);
         last  = $urandom_range(0, span - 1);
         if (first > last) begin
            swap  = first;
            first = last;
            last  = swap;
         end
         // sometimes run past the end so the clip is exercised
         if ($urandom_range(0, 7) == 0) last = $urandom_range(last, LEAVES - 1);
         it.range_start = IDX_BITS'(first);
         it.range_end   = IDX_BITS'(last);
      end
      return it;
   endfunction

   // Present one item, wait for its transfer, then predict
   task automatic run_item(input req_item_type it, input logic known,
                           input result_type known_result);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= it.req_type;
      req_ch.update_index <= it.update_index;
      req_ch.new_value    <= it.new_value;
      req_ch.range_start  <= it.range_start;
      req_ch.range_end    <= it.range_end;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (it.req_type == REQ_UPDATE) begin
         updates_sent++;
         apply_update(it.update_index, it.new_value);
      end else begin
         queries_sent++;
         pending_results.push_back(known ? known_result :
                                   predict_query(it.range_start, it.range_end));
      end
      @(negedge clock);
   endtask

   // Register write once the block has drained
   task automatic csr_write(input logic sel, input logic [SIZE_BITS-1:0] data);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= data;
      @(posedge clock);
      if (sel == CSR_FIND_MIN) mode_min = data[0];
      else size_reg = data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result side: random stall bursts on ready
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left   <= $urandom_range(0, 3);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result: expected none, got index %0d found %0b",
                     $time, rsp_ch.best_index, rsp_ch.found);
         end else begin
            oldest_result = pending_results.pop_front();
            results_checked++;
            if (rsp_ch.best_index !== oldest_result.best_index) begin
               mismatch_count++;
               $display("%0t: best_index mismatch: expected %0d, got %0d",
                        $time, oldest_result.best_index, rsp_ch.best_index);
            end
            if (rsp_ch.found !== oldest_result.found) begin
               mismatch_count++;
               $display("%0t: found mismatch: expected %0b, got %0b",
                        $time, oldest_result.found, rsp_ch.found);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding",
                  $time, pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int span;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_FIND_MIN;
      csr_write_data      = '0;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_UPDATE;
      req_ch.update_index = '0;
      req_ch.new_value    = '0;
      req_ch.range_start  = '0;
      req_ch.range_end    = '0;
      mode_min            = 1'b1;
      size_reg            = SIZE_BITS'(LEAVES);
      foreach (best_tree[n]) best_tree[n] = '0;

      // Directed table
      directed_rows.push_back(stim_query(0, 1023, 1'b1, 0, 1'b0));  // empty tree
      directed_rows.push_back(stim_update(0, 32'h8000_0000));
      directed_rows.push_back(stim_update(1023, 32'h7FFF_FFFF));
      directed_rows.push_back(stim_update(5, 32'h0000_0000));
      directed_rows.push_back(stim_query(0, 1023, 1'b1, 0, 1'b1));
      directed_rows.push_back(stim_query(1023, 0, 1'b1, 0, 1'b0));  // start after end
      directed_rows.push_back(stim_update(7, 32'h8000_0000));
      directed_rows.push_back(stim_query(0, 1023, 1'b1, 7, 1'b1));  // rightmost min
      directed_rows.push_back(stim_query(5, 5, 1'b1, 5, 1'b1));
      directed_rows.push_back(stim_csr(CSR_FIND_MIN, 0));
      directed_rows.push_back(stim_query(0, 1023, 1'b0, 0, 1'b0)); // nodes built for min
      directed_rows.push_back(stim_update(1023, 32'h7FFF_FFFF));
      directed_rows.push_back(stim_update(3, 32'h7FFF_FFFF));
      directed_rows.push_back(stim_query(0, 1023, 1'b0, 0, 1'b0));  // leftmost max
      directed_rows.push_back(stim_query(1, 1022, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_csr(CSR_ACTIVE_SIZE, 0));
      directed_rows.push_back(stim_update(0, 32'h0000_0001));        // dropped
      directed_rows.push_back(stim_query(0, 1023, 1'b1, 0, 1'b0));
      directed_rows.push_back(stim_csr(CSR_ACTIVE_SIZE, 2047));      // clamps to full
      directed_rows.push_back(stim_query(1023, 1023, 1'b1, 1023, 1'b1));
      directed_rows.push_back(stim_csr(CSR_ACTIVE_SIZE, 1));
      directed_rows.push_back(stim_update(1, 32'h0000_0005));        // dropped
      directed_rows.push_back(stim_query(0, 1023, 1'b1, 0, 1'b1));   // clipped to 0..0
      directed_rows.push_back(stim_query(1, 5, 1'b1, 0, 1'b0));      // empty after clip
      directed_rows.push_back(stim_csr(CSR_ACTIVE_SIZE, 8));         // shrunk size
      directed_rows.push_back(stim_query(0, 1023, 1'b0, 0, 1'b0));
      directed_rows.push_back(stim_update(6, 32'hFFFF_FFFF));
      directed_rows.push_back(stim_query(2, 1023, 1'b0, 0, 1'b0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR)
            csr_write(directed_rows[r].csr_sel, directed_rows[r].csr_data);
         else
            run_item(directed_rows[r].item, directed_rows[r].known,
                     directed_rows[r].known_result);
      end

      // Random phases over mode and size settings; the last one runs flat out
      for (int ph = 0; ph < PHASES; ph++) begin
         csr_write(CSR_FIND_MIN, SIZE_BITS'(phase_min[ph]));
         csr_write(CSR_ACTIVE_SIZE, SIZE_BITS'(phase_size[ph]));
         if (ph == PHASES - 1) idle_on = 1'b0;
         span = clamp_size(size_reg);
         repeat (phase_items[ph]) run_item(random_request(span), 1'b0, '0);
      end

      // Drain
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d updates and %0d queries, %0d results checked,",
               updates_sent, queries_sent, results_checked);
      $display("over min and max modes with sizes from 0 up to past the tree.");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
